>>> sv/ntcc_pkg.sv
// Shared constants and types for the thermistor-to-Celsius converter.
`default_nettype none

package ntcc_pkg;

    localparam int CODE_W  = 10;
    localparam int PAD_W   = 20;
    localparam int TEMP_W  = 15;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PAD_W-1:0] PAD_RESET = 20'd9850;

    // Register index taken from paddr[2]
    localparam logic REG_PAD = 1'b0;

    // Log2 mantissa fraction bits and squaring rounds
    localparam int LOG_FRAC = 31;

    // Steinhart-Hart coefficients in Q46, ln 2 in Q32
    localparam logic [46:0] COEF_A_Q46 = 47'd79456726751;
    localparam logic [34:0] COEF_B_Q46 = 35'd16475082231;
    localparam logic [22:0] COEF_C_Q46 = 23'd6169516;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;

    // Centikelvin quotient fits in 17 bits since D >= A
    localparam int CK_W = 17;
    localparam logic [CK_W:0] ZERO_C_CENTI = 18'd27315;
    localparam logic signed [CK_W:0] TEMP_MIN = -18'sd5500;
    localparam logic signed [CK_W:0] TEMP_MAX = 18'sd15000;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_NOVAL = 2'd1,
        STAT_LOW   = 2'd2,
        STAT_HIGH  = 2'd3
    } status_t;

endpackage

`default_nettype wire

>>> sv/ntcc_in_if.sv
// Input channel carrying one ADC reading per item.
`default_nettype none

interface ntcc_in_if
    import ntcc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

`default_nettype wire

>>> sv/ntcc_out_if.sv
// Output channel carrying one temperature result per item.
`default_nettype none

interface ntcc_out_if
    import ntcc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temp_centi_c;
    logic [STAT_W-1:0]        status;

    modport source (output valid, output temp_centi_c, output status, input ready);
    modport sink   (input valid, input temp_centi_c, input status, output ready);
endinterface

`default_nettype wire

>>> sv/ntcc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module ntcc_div_pipe
    import ntcc_pkg::*;
#(
    parameter int NW = 31,
    parameter int DW = 10,
    parameter int QW = 31,
    parameter int TW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [TW-1:0] in_tag,
    output logic               out_valid,
    output logic [QW-1:0]      quo,
    output logic [TW-1:0]      out_tag
);

    logic [QW-1:0] vld_reg;
    logic [DW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [QW-1:0] low_reg [QW];
    logic [TW-1:0] tag_reg [QW];

    for (genvar s = 0; s < QW; s++) begin : g_step
        logic          v_cur;
        logic [DW-1:0] rem_cur;
        logic [DW-1:0] den_cur;
        logic [QW-1:0] q_cur;
        logic [QW-1:0] low_cur;
        logic [TW-1:0] tag_cur;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;

        if (s == 0) begin : g_first
            // High part of the numerator is known to be below the divisor
            assign v_cur   = in_valid;
            assign rem_cur = DW'(num >> QW);
            assign den_cur = den;
            assign q_cur   = '0;
            assign low_cur = QW'(num);
            assign tag_cur = in_tag;
        end else begin : g_next
            assign v_cur   = vld_reg[s-1];
            assign rem_cur = rem_reg[s-1];
            assign den_cur = den_reg[s-1];
            assign q_cur   = q_reg[s-1];
            assign low_cur = low_reg[s-1];
            assign tag_cur = tag_reg[s-1];
        end

        assign trial = {rem_cur, low_cur[QW-1-s]};
        assign ge    = trial >= {1'b0, den_cur};
        assign diff  = trial - {1'b0, den_cur};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s] <= ge ? DW'(diff) : DW'(trial);
                q_reg[s]   <= QW'({q_cur, ge});
                den_reg[s] <= den_cur;
                low_reg[s] <= low_cur;
                tag_reg[s] <= tag_cur;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

`default_nettype wire

>>> sv/ntcc_ln_pipe.sv
// Pipelined natural log: normalize, 31 squaring rounds, scale by ln 2.
`default_nettype none

module ntcc_ln_pipe
    import ntcc_pkg::*;
#(
    parameter int NW = 31,
    parameter int KW = 5,
    parameter int YW = 30,
    parameter int TW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] r,
    input  wire logic [TW-1:0] in_tag,
    output logic               out_valid,
    output logic [YW-1:0]      y,
    output logic [TW-1:0]      out_tag
);

    localparam int SHW = NW + LOG_FRAC;
    localparam int LVW = KW + LOG_FRAC - 7;
    localparam int LPW = LVW + 33;

    // Leading-one search
    logic          a_vld_reg;
    logic [NW-1:0] a_r_reg;
    logic [KW-1:0] a_k_reg;
    logic [TW-1:0] a_tag_reg;
    logic [KW-1:0] k_next;

    // Mantissa normalize
    logic                b_vld_reg;
    logic [LOG_FRAC:0]   b_m_reg;
    logic [KW-1:0]       b_k_reg;
    logic [TW-1:0]       b_tag_reg;
    logic [SHW-1:0]      shifted;

    // Squaring rounds
    logic [LOG_FRAC-1:0] sq_vld_reg;
    logic [LOG_FRAC:0]   sq_m_reg [LOG_FRAC];
    logic [LOG_FRAC-1:0] sq_f_reg [LOG_FRAC];
    logic [KW-1:0]       sq_k_reg [LOG_FRAC];
    logic [TW-1:0]       sq_tag_reg [LOG_FRAC];

    // Scale to natural log
    logic           y_vld_reg;
    logic [YW-1:0]  y_reg;
    logic [TW-1:0]  y_tag_reg;
    logic [LVW-1:0] lv;
    logic [LPW-1:0] lprod;

    always_comb
    begin
        k_next = '0;
        for (int i = 0; i < NW; i++)
        begin
            if (r[i])
            begin
                k_next = KW'(i);
            end
        end
    end

    assign shifted = {a_r_reg, {LOG_FRAC{1'b0}}} >> a_k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            y_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            y_vld_reg <= sq_vld_reg[LOG_FRAC-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_r_reg   <= r;
            a_k_reg   <= k_next;
            a_tag_reg <= in_tag;
            b_m_reg   <= shifted[LOG_FRAC:0];
            b_k_reg   <= a_k_reg;
            b_tag_reg <= a_tag_reg;
            y_reg     <= YW'(lprod >> 32);
            y_tag_reg <= sq_tag_reg[LOG_FRAC-1];
        end
    end

    for (genvar i = 0; i < LOG_FRAC; i++) begin : g_sq
        logic                v_cur;
        logic [LOG_FRAC:0]   m_cur;
        logic [LOG_FRAC-1:0] f_cur;
        logic [KW-1:0]       k_cur;
        logic [TW-1:0]       tag_cur;
        logic [63:0]         prod;
        logic [32:0]         t;

        if (i == 0) begin : g_first
            assign v_cur   = b_vld_reg;
            assign m_cur   = b_m_reg;
            assign f_cur   = '0;
            assign k_cur   = b_k_reg;
            assign tag_cur = b_tag_reg;
        end else begin : g_next
            assign v_cur   = sq_vld_reg[i-1];
            assign m_cur   = sq_m_reg[i-1];
            assign f_cur   = sq_f_reg[i-1];
            assign k_cur   = sq_k_reg[i-1];
            assign tag_cur = sq_tag_reg[i-1];
        end

        assign prod = 64'(m_cur) * 64'(m_cur);
        assign t    = prod[63:31];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                sq_vld_reg[i] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                // Square overflowed past 2: halve and emit a one bit
                if (t[32])
                begin
                    sq_m_reg[i] <= t[32:1];
                    sq_f_reg[i] <= f_cur | (LOG_FRAC'(1) << (LOG_FRAC - 1 - i));
                end
                else
                begin
                    sq_m_reg[i] <= t[31:0];
                    sq_f_reg[i] <= f_cur;
                end
                sq_k_reg[i]   <= k_cur;
                sq_tag_reg[i] <= tag_cur;
            end
        end
    end

    assign lv    = {sq_k_reg[LOG_FRAC-1], sq_f_reg[LOG_FRAC-1][LOG_FRAC-1:7]};
    assign lprod = LPW'(lv) * LPW'(LN2_Q32) + (LPW'(1) << 31);

    assign out_valid = y_vld_reg;
    assign y         = y_reg;
    assign out_tag   = y_tag_reg;

endmodule

`default_nettype wire

>>> sv/ntcc_poly_pipe.sv
// Steinhart-Hart denominator: y^2, y^3, coefficient terms and sum, plus the rounded dividend.
`default_nettype none

module ntcc_poly_pipe
    import ntcc_pkg::*;
#(
    parameter int YW  = 30,
    parameter int DW  = 49,
    parameter int NMW = 55
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire logic [YW-1:0] y,
    input  wire logic          in_err,
    output logic               out_valid,
    output logic [DW-1:0]      den,
    output logic [NMW-1:0]     num,
    output logic               out_err
);

    localparam int Y2W = 2 * YW - 23;
    localparam int Y3W = Y2W + YW - 23;
    localparam int P2W = 2 * YW + 1;
    localparam int P3W = Y2W + YW + 1;
    localparam int PBW = 35 + YW + 1;
    localparam int PCW = 23 + Y3W + 1;

    logic [3:0] vld_reg;
    logic [3:0] err_reg;

    logic [YW-1:0]  s1_y_reg;
    logic [Y2W-1:0] s1_y2_reg;
    logic [YW-1:0]  s2_y_reg;
    logic [Y3W-1:0] s2_y3_reg;
    logic [DW-1:0]  s3_tb_reg;
    logic [DW-1:0]  s3_tc_reg;
    logic [DW-1:0]  s4_d_reg;
    logic [NMW-1:0] s4_n_reg;

    logic [P2W-1:0] p2;
    logic [P3W-1:0] p3;
    logic [PBW-1:0] pb;
    logic [PCW-1:0] pc;
    logic [DW-1:0]  d_next;

    assign p2 = P2W'(y) * P2W'(y) + (P2W'(1) << 23);
    assign p3 = P3W'(s1_y2_reg) * P3W'(s1_y_reg) + (P3W'(1) << 23);
    assign pb = PBW'(COEF_B_Q46) * PBW'(s2_y_reg) + (PBW'(1) << 23);
    assign pc = PCW'(COEF_C_Q46) * PCW'(s2_y3_reg) + (PCW'(1) << 23);
    assign d_next = DW'(COEF_A_Q46) + s3_tb_reg + s3_tc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err_reg   <= {err_reg[2:0], in_err};
            s1_y_reg  <= y;
            s1_y2_reg <= Y2W'(p2 >> 24);
            s2_y_reg  <= s1_y_reg;
            s2_y3_reg <= Y3W'(p3 >> 24);
            s3_tb_reg <= DW'(pb >> 24);
            s3_tc_reg <= DW'(pc >> 24);
            s4_d_reg  <= d_next;
            // Dividend 100 * 2^46 plus half the divisor rounds the quotient
            s4_n_reg  <= (NMW'(100) << 46) + NMW'(d_next >> 1);
        end
    end

    assign out_valid = vld_reg[3];
    assign den       = s4_d_reg;
    assign num       = s4_n_reg;
    assign out_err   = err_reg[3];

endmodule

`default_nettype wire

>>> sv/ntc_thermistor_to_celsius.sv
// Top level: thermistor ADC code to Celsius in hundredths, fully pipelined.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------
//  sample   | in  | valid/ready    | adc_code[9:0]
//  result   | out | valid/ready    | temp_centi_c[14:0] signed, status[1:0]
//  apb      | in  | psel/penable   | paddr[2:0], pwdata/prdata[31:0], pad_ohms
//
//  One item enters per cycle while no result is held at the output. The resistance
//  width NW is 20 plus the bits of ADC_FULL_SCALE. Most of the pipeline depth
//  comes from the two bit-per-stage dividers and the 31 squaring rounds.
//  Reset clears all valid bits and loads pad_ohms with 9850.
//  A result held at the output stalls every stage together; nothing is dropped.
`default_nettype none

module ntc_thermistor_to_celsius
    import ntcc_pkg::*;
#(
    parameter int ADC_FULL_SCALE = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    ntcc_in_if.sink                 sample,
    ntcc_out_if.source              result
);

    localparam int FW   = $clog2(ADC_FULL_SCALE + 1);
    localparam int CMPW = ((FW > CODE_W) ? FW : CODE_W) + 1;
    localparam int NW   = PAD_W + FW;
    localparam int KW   = $clog2(NW);
    localparam int YW   = KW + 25;
    localparam int Y2W  = 2 * YW - 23;
    localparam int Y3W  = Y2W + YW - 23;
    localparam int TBW  = 35 + YW - 23;
    localparam int TCW  = Y3W;
    localparam int DMX  = (TBW > TCW) ? TBW : TCW;
    localparam int DW   = ((DMX > 47) ? DMX : 47) + 2;
    localparam int NMW  = ((DW > 54) ? DW : 54) + 1;

    logic [PAD_W-1:0] pad_reg;
    logic             adv;

    // Front stage
    logic              f_vld_reg;
    logic              f_err_reg;
    logic [NW-1:0]     f_num_reg;
    logic [CODE_W-1:0] f_code_reg;
    logic              code_bad;
    logic [FW-1:0]     span;

    logic          r_vld;
    logic [NW-1:0] r_val;
    logic          r_err;

    logic          y_vld;
    logic [YW-1:0] y_val;
    logic          y_err;

    logic           d_vld;
    logic [DW-1:0]  d_val;
    logic [NMW-1:0] n_val;
    logic           d_err;

    logic            ck_vld;
    logic [CK_W-1:0] ck_val;
    logic            ck_err;

    logic signed [CK_W:0] c_raw;
    logic signed [CK_W:0] c_sat;
    status_t              stat_next;

    logic                     out_vld_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;
    status_t                  out_stat_reg;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PAD) ? PDATA_W'(pad_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg <= PAD_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_PAD)
        begin
            pad_reg <= pwdata[PAD_W-1:0];
        end
    end

    // Advance all stages unless a result is held
    assign adv          = !out_vld_reg || result.ready;
    assign sample.ready = adv;

    assign code_bad = (sample.adc_code == '0) ||
                      (CMPW'(sample.adc_code) >= CMPW'(ADC_FULL_SCALE));
    assign span     = FW'(CMPW'(ADC_FULL_SCALE) - CMPW'(sample.adc_code));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_vld_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_err_reg  <= code_bad;
            f_num_reg  <= NW'(pad_reg) * NW'(span);
            f_code_reg <= sample.adc_code;
        end
    end

    ntcc_div_pipe #(
        .NW(NW), .DW(CODE_W), .QW(NW), .TW(1)
    ) u_rdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_vld_reg),
        .num       (f_num_reg),
        .den       (f_code_reg),
        .in_tag    (f_err_reg),
        .out_valid (r_vld),
        .quo       (r_val),
        .out_tag   (r_err)
    );

    ntcc_ln_pipe #(
        .NW(NW), .KW(KW), .YW(YW), .TW(1)
    ) u_ln (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (r_vld),
        .r         (r_val),
        .in_tag    (r_err || (r_val == '0)),
        .out_valid (y_vld),
        .y         (y_val),
        .out_tag   (y_err)
    );

    ntcc_poly_pipe #(
        .YW(YW), .DW(DW), .NMW(NMW)
    ) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (y_vld),
        .y         (y_val),
        .in_err    (y_err),
        .out_valid (d_vld),
        .den       (d_val),
        .num       (n_val),
        .out_err   (d_err)
    );

    ntcc_div_pipe #(
        .NW(NMW), .DW(DW), .QW(CK_W), .TW(1)
    ) u_kdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_vld),
        .num       (n_val),
        .den       (d_val),
        .in_tag    (d_err),
        .out_valid (ck_vld),
        .quo       (ck_val),
        .out_tag   (ck_err)
    );

    // Offset to Celsius, saturate, and report errored readings as no value
    assign c_raw = $signed({1'b0, ck_val}) - $signed(ZERO_C_CENTI);

    always_comb
    begin
        c_sat     = c_raw;
        stat_next = STAT_OK;
        if (ck_err)
        begin
            c_sat     = '0;
            stat_next = STAT_NOVAL;
        end
        else if (c_raw < TEMP_MIN)
        begin
            c_sat     = TEMP_MIN;
            stat_next = STAT_LOW;
        end
        else if (c_raw > TEMP_MAX)
        begin
            c_sat     = TEMP_MAX;
            stat_next = STAT_HIGH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= ck_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_temp_reg <= TEMP_W'(c_sat);
            out_stat_reg <= stat_next;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.temp_centi_c = out_temp_reg;
    assign result.status       = out_stat_reg;

endmodule

`default_nettype wire
